[src/dlpq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the ladder path query block.
// No dependencies; imported by every module of the block.
package dlpq_pkg;

	localparam int ROW_COUNT = 16;
	localparam int LEVELS    = ROW_COUNT - 1;
	localparam int IDX_W     = 4;
	localparam int QRY_W     = 5;
	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 8;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic [ROW_COUNT-1:0] row_t;
	typedef logic [LEVELS-1:0][ROW_COUNT-1:0] reach_t;
	typedef logic [LEVELS-1:0] level_t;

endpackage

[src/dlpq_level_unit.sv]
`timescale 1ns / 1ps
// Shared level unit: from one masked adjacency row and the per-level reach
// vectors, decides for every path length whether the current vertex reaches it.
// Depends on dlpq_pkg.
module dlpq_level_unit (
	input  dlpq_pkg::row_t   row_m,
	input  dlpq_pkg::reach_t reach,
	output dlpq_pkg::level_t hit
);
	import dlpq_pkg::*;

	always_comb begin
		hit[0] = |row_m;
		for (int i = 1; i < LEVELS; i++) begin
			hit[i] = |(row_m & reach[i-1]);
		end
	end

endmodule

[src/dag_ladder_path_query.sv]
`timescale 1ns / 1ps
// Top level of the ladder path query block: adjacency storage, sweep sequencer
// and stream ports. Depends on dlpq_pkg and dlpq_level_unit.
//
// A write request stores one 16-bit adjacency row and returns nothing. A query
// request goes straight to the done state, with no sweep, when the start or
// length is out of range or the length is zero; otherwise the block sweeps the
// vertices from 15 down to the start vertex, one vertex per cycle through the
// shared level unit, then passes through the done state to the output register.
// The input is not ready from the acceptance of a query until its answer sits
// in the output register.
module dag_ladder_path_query #(
	parameter int VERTICES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// [3:0] row_index, [19:4] row_bits, [24:20] start_vertex,
	// [29:25] ladder_length, [31:30] zero
	input  logic [dlpq_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// [0] opcode
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [0] found, [7:1] zero
	output logic [dlpq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import dlpq_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_DONE  = 2'd2;
	localparam int VCMP_W = 7;

	logic [1:0]       state_q;
	row_t             adj_q [ROW_COUNT];
	reach_t           reach_q;
	logic [IDX_W-1:0] u_q;
	logic [IDX_W-1:0] start_q;
	logic [IDX_W-1:0] len_q;
	logic             res_q;
	logic             m_valid_q;
	logic             m_found_q;

	logic [IDX_W-1:0] row_index;
	row_t             row_bits;
	logic [QRY_W-1:0] start_vertex;
	logic [QRY_W-1:0] ladder_length;
	logic             s_fire;
	logic             m_fire;
	logic             out_load;
	logic             in_range;
	row_t             live_mask;
	row_t             hi_mask;
	row_t             row_m;
	level_t           hit;

	assign row_index     = s_axis_tdata[3:0];
	assign row_bits      = s_axis_tdata[19:4];
	assign start_vertex  = s_axis_tdata[24:20];
	assign ladder_length = s_axis_tdata[29:25];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign m_fire        = m_valid_q && m_axis_tready;
	assign out_load      = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, m_found_q};

	assign in_range = ({{(VCMP_W-QRY_W){1'b0}}, start_vertex} < VCMP_W'(VERTICES))
		&& ({{(VCMP_W-QRY_W){1'b0}}, ladder_length} < VCMP_W'(VERTICES));

	always_comb begin
		for (int j = 0; j < ROW_COUNT; j++) begin
			live_mask[j] = (j < VERTICES);
		end
	end

	assign hi_mask = (row_t'({ROW_COUNT{1'b1}}) << u_q) & ~(row_t'(1) << u_q);
	assign row_m   = adj_q[u_q] & hi_mask & live_mask;

	dlpq_level_unit u_level (
		.row_m (row_m),
		.reach (reach_q),
		.hit   (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROW_COUNT; r++) begin
				adj_q[r] <= '0;
			end
		end else if (s_fire && s_axis_tuser == OP_WRITE) begin
			adj_q[row_index] <= row_bits;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SWEEP) begin
			for (int i = 0; i < LEVELS; i++) begin
				reach_q[i][u_q] <= hit[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			u_q       <= '0;
			m_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire && s_axis_tuser == OP_QUERY) begin
						if (in_range && ladder_length != '0 && !start_vertex[QRY_W-1]
							&& !ladder_length[QRY_W-1]) begin
							u_q     <= '1;
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SWEEP: begin
					if (u_q == start_q) begin
						state_q <= ST_DONE;
					end else begin
						u_q <= u_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_fire) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire && s_axis_tuser == OP_QUERY) begin
			start_q <= start_vertex[IDX_W-1:0];
			len_q   <= ladder_length[IDX_W-1:0];
			res_q   <= in_range && (ladder_length == '0);
		end else if (state_q == ST_SWEEP && u_q == start_q) begin
			res_q <= hit[len_q - 1'b1];
		end
		if (out_load) begin
			m_found_q <= res_q;
		end
	end

endmodule

[src/dlpq_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the ladder path query block, bound to the top level.
// Depends on dlpq_pkg and dag_ladder_path_query.
module dlpq_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic s_axis_tuser,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [dlpq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import dlpq_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed or dropped");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_QUERY |=> !s_axis_tready)
		else $error("input ready right after a query request");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_WRITE |=> !$rose(m_axis_tvalid))
		else $error("result raised after a write request");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without a query in flight");

endmodule

bind dag_ladder_path_query dlpq_checker u_dlpq_checker (.*);
